// ----- sv/shape_fill_rasterizer_unit_defines.svh -----
// Assertion helpers for the rasteriser control logic.
// Both macros clock on clk_i; SFR_ASSERT is also disabled while rst_ni is low.
`ifndef SHAPE_FILL_RASTERIZER_UNIT_DEFINES_SVH
`define SHAPE_FILL_RASTERIZER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SFR_ASSERT(lbl, prop, msg)
`define SFR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/sfr_pkg.sv -----
`default_nettype none
package sfr_pkg;

  localparam logic [7:0] BLANK_CHAR     = 8'd46;
  localparam logic [6:0] CFG_SIZE_RESET = 7'd64;

  // configuration register indexes
  localparam logic REG_CANVAS_WIDTH  = 1'b0;
  localparam logic REG_CANVAS_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    OP_RECT    = 3'd0,
    OP_UP      = 3'd1,
    OP_DOWN    = 3'd2,
    OP_DIAMOND = 3'd3,
    OP_CLEAR   = 3'd4,
    OP_READ    = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISP,
    ST_ROW,
    ST_SPAN,
    ST_CLEAR,
    ST_RD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic take;
    logic row_eval;
    logic row_next;
    logic pix_wr;
    logic clr_start;
    logic clr_wr;
    logic rd_issue;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic h_zero;
    logic row_hit;
    logic row_last;
    logic span_last;
    logic clr_last;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// ----- sv/sfr_ctrl.sv -----
`default_nettype none
`include "shape_fill_rasterizer_unit_defines.svh"
module sfr_ctrl
  import sfr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISP;
      end
      ST_DISP: begin
        case (sts_i.op)
          OP_RECT, OP_UP, OP_DOWN, OP_DIAMOND: begin
            state_d = sts_i.h_zero ? ST_DONE : ST_ROW;
          end
          OP_CLEAR: state_d = ST_CLEAR;
          OP_READ:  state_d = ST_RD;
          default:  state_d = ST_DONE;
        endcase
      end
      ST_ROW: begin
        if (sts_i.row_hit)       state_d = ST_SPAN;
        else if (sts_i.row_last) state_d = ST_DONE;
      end
      ST_SPAN: begin
        if (sts_i.span_last) state_d = sts_i.row_last ? ST_DONE : ST_ROW;
      end
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_DONE;
      end
      ST_RD: state_d = ST_DONE;
      ST_DONE: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT:  cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_DISP:  cmd_o.clr_start = (sts_i.op == OP_CLEAR);
      ST_ROW: begin
        cmd_o.row_eval = 1'b1;
        cmd_o.row_next = !sts_i.row_hit && !sts_i.row_last;
      end
      ST_SPAN: begin
        cmd_o.pix_wr   = 1'b1;
        cmd_o.row_next = sts_i.span_last && !sts_i.row_last;
      end
      ST_CLEAR: cmd_o.clr_wr   = 1'b1;
      ST_RD:    cmd_o.rd_issue = 1'b1;
      ST_DONE:  cmd_o.res_load = !sts_i.out_busy;
      default: ;
    endcase
  end

  `SFR_ASSERT(a_take_dispatch, cmd_o.take |=> (state_q == ST_DISP), "accepted word not dispatched")
  `SFR_ASSERT(a_load_free, cmd_o.res_load |-> !sts_i.out_busy, "result loaded over pending word")
  `SFR_ASSERT(a_wr_excl, cmd_o.pix_wr |-> (!cmd_o.clr_wr && !in_ready_o), "store write conflict")
  `SFR_ASSERT(a_load_idle, cmd_o.res_load |=> (state_q == ST_IDLE), "no return to idle")

endmodule
`default_nettype wire

// ----- sv/sfr_dpath.sv -----
`default_nettype none
module sfr_dpath
  import sfr_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [6:0]        cfg_wdata_i,
  input  wire logic [2:0]        operation_i,
  input  wire logic signed [7:0] x_origin_i,
  input  wire logic signed [7:0] y_origin_i,
  input  wire logic [6:0]        shape_width_i,
  input  wire logic [6:0]        shape_height_i,
  input  wire logic [7:0]        brush_i,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [7:0]             pixel_value_o,
  output logic                   in_bounds_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [AW-1:0] STRIDE    = AW'(MAX_WIDTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [9:0]    MAXW10    = 10'(MAX_WIDTH);
  localparam logic [9:0]    MAXH10    = 10'(MAX_HEIGHT);

  // configuration
  logic [6:0] cfg_w_q, cfg_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= CFG_SIZE_RESET;
      cfg_h_q <= CFG_SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CANVAS_WIDTH:  cfg_w_q <= cfg_wdata_i;
        REG_CANVAS_HEIGHT: cfg_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // item registers
  op_e              op_q;
  logic signed [7:0] x_q, y_q;
  logic [6:0]       w_q, h_q, i_q;
  logic [7:0]       brush_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q    <= op_e'(operation_i);
      x_q     <= x_origin_i;
      y_q     <= y_origin_i;
      w_q     <= shape_width_i;
      h_q     <= shape_height_i;
      brush_q <= brush_i;
      i_q     <= '0;
    end else if (cmd_i.row_next) begin
      i_q <= i_q + 7'd1;
    end
  end

  // effective canvas size and per-row span
  logic [9:0]        effw_u, effh_u;
  logic signed [9:0] effw, effh, x10, y10, i10, w10, h10, half10;
  logic signed [9:0] row10, xl, xr, lo, hi;
  logic              row_ok;

  always_comb begin
    effw_u = ({3'b000, cfg_w_q} > MAXW10) ? MAXW10 : {3'b000, cfg_w_q};
    effh_u = ({3'b000, cfg_h_q} > MAXH10) ? MAXH10 : {3'b000, cfg_h_q};
    effw   = signed'(effw_u);
    effh   = signed'(effh_u);
    x10    = {{2{x_q[7]}}, x_q};
    y10    = {{2{y_q[7]}}, y_q};
    i10    = signed'({3'b000, i_q});
    w10    = signed'({3'b000, w_q});
    h10    = signed'({3'b000, h_q});
    half10 = h10 >>> 1;
    row10  = y10 + i10;
    case (op_q)
      OP_UP: begin
        xl = x10 - i10;
        xr = x10 + i10;
      end
      OP_DOWN: begin
        xl = x10 + i10 - h10 + 10'sd1;
        xr = x10 + h10 - 10'sd1 - i10;
      end
      OP_DIAMOND: begin
        if (i10 < half10) begin
          xl = x10 - i10;
          xr = x10 + i10;
        end else begin
          xl = x10 + i10 - h10 + 10'sd1;
          xr = x10 + h10 - 10'sd1 - i10;
        end
      end
      default: begin
        xl = x10;
        xr = x10 + w10 - 10'sd1;
      end
    endcase
    lo     = (xl < 10'sd0) ? 10'sd0 : xl;
    hi     = (xr > effw - 10'sd1) ? effw - 10'sd1 : xr;
    row_ok = (row10 >= 10'sd0) && (row10 < effh);
  end

  logic [CW-1:0] col_q, hi_q;
  logic [AW-1:0] base_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_eval) begin
      col_q  <= lo[CW-1:0];
      hi_q   <= hi[CW-1:0];
      base_q <= AW'(row10[RW-1:0]) * STRIDE;
    end else if (cmd_i.pix_wr) begin
      col_q <= col_q + CW'(1);
    end
  end

  // clear sweep, also run once after reset
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_start) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // pixel read
  logic          rd_ok, inb_rd_q;
  logic [AW-1:0] rd_addr;

  assign rd_ok   = (x10 >= 10'sd0) && (y10 >= 10'sd0) && (x10 < effw) && (y10 < effh);
  assign rd_addr = AW'(y10[RW-1:0]) * STRIDE + AW'(x10[CW-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) inb_rd_q <= rd_ok;
  end

  // pixel store
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_q, wdata;
  logic [AW-1:0] waddr;
  logic          we;

  assign we    = cmd_i.pix_wr || cmd_i.clr_wr;
  assign waddr = cmd_i.clr_wr ? clr_cnt_q : base_q + AW'(col_q);
  assign wdata = cmd_i.clr_wr ? BLANK_CHAR : brush_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (cmd_i.rd_issue && rd_ok) rdata_q <= mem[rd_addr];
  end

  // result register
  logic       out_valid_q, inb_q;
  logic [7:0] pixel_q;
  logic       is_read;

  assign is_read = (op_q == OP_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      pixel_q <= (is_read && inb_rd_q) ? rdata_q : 8'd0;
      inb_q   <= is_read && inb_rd_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = pixel_q;
  assign in_bounds_o   = inb_q;

  always_comb begin
    sts_o           = '0;
    sts_o.op        = op_q;
    sts_o.h_zero    = (h_q == 7'd0);
    sts_o.row_hit   = row_ok && (lo <= hi);
    sts_o.row_last  = ({1'b0, i_q} + 8'd1) == {1'b0, h_q};
    sts_o.span_last = (col_q == hi_q);
    sts_o.clr_last  = (clr_cnt_q == LAST_ADDR);
    sts_o.out_busy  = out_valid_q && !out_ready_i;
  end

endmodule
`default_nettype wire

// ----- sv/shape_fill_rasterizer_unit.sv -----
`default_nettype none
// Character framebuffer of MAX_WIDTH x MAX_HEIGHT bytes with clipped shape
// fill. After reset the store is swept to '.' one byte per cycle, so no word
// is taken until that sweep has finished (configuration writes are accepted
// throughout). A shape evaluates each row of its height in turn and writes
// each pixel that lands inside the canvas one at a time: the single write
// port of the store sets that pace. A clear sweeps the whole store to '.'
// again; a pixel read is a single read of the store. One word is in work
// at a time; a finished result waits in an output register while the next
// word is accepted. Resize by writing the size registers, then clear.
module shape_fill_rasterizer_unit
  import sfr_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [6:0]        cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [2:0]        operation_i,
  input  wire logic signed [7:0] x_origin_i,
  input  wire logic signed [7:0] y_origin_i,
  input  wire logic [6:0]        shape_width_i,
  input  wire logic [6:0]        shape_height_i,
  input  wire logic [7:0]        brush_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             pixel_value_o,
  output logic                   in_bounds_o
);

  cmd_t cmd;
  sts_t sts;

  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfr_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (operation_i),
    .x_origin_i     (x_origin_i),
    .y_origin_i     (y_origin_i),
    .shape_width_i  (shape_width_i),
    .shape_height_i (shape_height_i),
    .brush_i        (brush_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .pixel_value_o  (pixel_value_o),
    .in_bounds_o    (in_bounds_o)
  );

endmodule
`default_nettype wire
